[hdl/fpsa_pkg.sv]
// Shared codes, register indexes and reset values for the free page stack allocator.
package fpsa_pkg;

    localparam int unsigned PAGE_SHIFT_DEFAULT = 12;
    localparam int unsigned MAX_PAGES_DEFAULT  = 32768;

    localparam logic [1:0] CMD_FREE  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;
    localparam logic [1:0] STATUS_FULL     = 2'd3;

    localparam logic REG_REGION_START = 1'b0;
    localparam logic REG_REGION_LIMIT = 1'b1;

    localparam logic [31:0] REGION_START_RESET = 32'h8002_0000;
    localparam logic [31:0] REGION_LIMIT_RESET = 32'h8800_0000;

endpackage

[hdl/fpsa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module fpsa_ram
    import fpsa_pkg::*;
#(
    parameter int unsigned WIDTH = 20,
    parameter int unsigned DEPTH = MAX_PAGES_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/free_page_stack_allocator.sv]
// Top level of the free page stack allocator: command decode, stack control and result register.
//
// Usage:
//   Input channel (s_*): one command item per handshake: free a page, allocate
//   a page or initialize the free list from the region registers.
//   Result channel (m_*): exactly one result item per command, in order.
//   Configuration: cfg_wr_en writes cfg_wr_data to region_start (index 0) or
//   region_limit (index 1) at the clock edge; write only while idle.
// Timing and throughput:
//   Free and unknown commands: result valid in the cycle after acceptance.
//   Allocate: registered stack RAM read, then ST_ALLOC loads the result; if empty, as for free.
//   Initialize: one RAM write per cycle for each page pushed, then the result is loaded.
//   One item is in work at a time; a new item is accepted once the block is
//   idle and the result register is empty or being taken in that cycle.
// Reset: the stack is empty and the region registers return to their
//   default values; the stack RAM contents are not cleared.
// Receiver stall: the result is held in the output register and input is
//   not accepted until the result is taken.
module free_page_stack_allocator
    import fpsa_pkg::*;
#(
    parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEFAULT,
    parameter int unsigned MAX_PAGES  = MAX_PAGES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_page_address,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_granted_address,
    output logic [1:0]  m_status,
    output logic [15:0] m_free_count
);

    localparam int unsigned AW  = $clog2(MAX_PAGES);
    localparam int unsigned CW  = $clog2(MAX_PAGES + 1);
    localparam int unsigned PNW = 32 - PAGE_SHIFT;
    localparam logic [32:0] PAGE_BYTES = 33'(1) << PAGE_SHIFT;
    localparam logic [32:0] PAGE_MASK  = PAGE_BYTES - 33'(1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PAGES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ALLOC = 3'b010,
        ST_INIT  = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [31:0]     region_start_reg, region_start_next;
    logic [31:0]     region_limit_reg, region_limit_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [32:0]     init_addr_reg, init_addr_next;
    logic            m_valid_reg, m_valid_next;
    logic [31:0]     granted_reg, granted_next;
    logic [1:0]      status_reg, status_next;
    logic [15:0]     free_count_reg, free_count_next;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    logic [PNW-1:0]  ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [PNW-1:0]  ram_rd_data;

    logic            accept;
    logic            stack_full;
    logic            addr_bad;
    logic [CW-1:0]   count_dec;
    logic [32:0]     init_end;
    logic            init_fits;
    logic [32:0]     init_first;

    fpsa_ram #(
        .WIDTH (PNW),
        .DEPTH (MAX_PAGES)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    assign stack_full = count_reg >= COUNT_MAX;
    assign count_dec  = count_reg - CW'(1);
    assign addr_bad   = (s_page_address[PAGE_SHIFT-1:0] != '0)
                     || (s_page_address < region_start_reg)
                     || (s_page_address >= region_limit_reg);
    assign init_first = ({1'b0, region_start_reg} + PAGE_MASK) & ~PAGE_MASK;
    assign init_end   = init_addr_reg + PAGE_BYTES;
    assign init_fits  = init_end <= {1'b0, region_limit_reg};

    function automatic logic [15:0] count16(input logic [CW-1:0] c);
        logic [CW+15:0] wide;
        wide = {{16{1'b0}}, c};
        return wide[15:0];
    endfunction

    always_comb begin
        state_next        = state_reg;
        region_start_next = region_start_reg;
        region_limit_next = region_limit_reg;
        count_next        = count_reg;
        init_addr_next    = init_addr_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        granted_next      = granted_reg;
        status_next       = status_reg;
        free_count_next   = free_count_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = count_reg[AW-1:0];
        ram_wr_data       = s_page_address[31:PAGE_SHIFT];
        ram_rd_en         = 1'b0;
        ram_rd_addr       = count_dec[AW-1:0];

        if (cfg_wr_en) begin
            if (cfg_index == REG_REGION_START) begin
                region_start_next = cfg_wr_data;
            end else begin
                region_limit_next = cfg_wr_data;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    granted_next = '0;
                    status_next  = STATUS_OK;
                    case (s_command)
                        CMD_FREE: begin
                            m_valid_next = 1'b1;
                            if (addr_bad) begin
                                status_next     = STATUS_BAD_ADDR;
                                free_count_next = count16(count_reg);
                            end else if (stack_full) begin
                                status_next     = STATUS_FULL;
                                free_count_next = count16(count_reg);
                            end else begin
                                ram_wr_en       = 1'b1;
                                count_next      = count_reg + CW'(1);
                                free_count_next = count16(count_reg + CW'(1));
                            end
                        end
                        CMD_ALLOC: begin
                            if (count_reg == '0) begin
                                m_valid_next    = 1'b1;
                                status_next     = STATUS_EMPTY;
                                free_count_next = count16(count_reg);
                            end else begin
                                ram_rd_en  = 1'b1;
                                count_next = count_dec;
                                state_next = ST_ALLOC;
                            end
                        end
                        CMD_INIT: begin
                            count_next     = '0;
                            init_addr_next = init_first;
                            state_next     = ST_INIT;
                        end
                        default: begin
                            m_valid_next    = 1'b1;
                            free_count_next = count16(count_reg);
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                m_valid_next    = 1'b1;
                granted_next    = {ram_rd_data, {PAGE_SHIFT{1'b0}}};
                status_next     = STATUS_OK;
                free_count_next = count16(count_reg);
                state_next      = ST_IDLE;
            end
            ST_INIT: begin
                if (!init_fits) begin
                    m_valid_next    = 1'b1;
                    status_next     = STATUS_OK;
                    free_count_next = count16(count_reg);
                    state_next      = ST_IDLE;
                end else if (stack_full) begin
                    m_valid_next    = 1'b1;
                    status_next     = STATUS_FULL;
                    free_count_next = count16(count_reg);
                    state_next      = ST_IDLE;
                end else begin
                    ram_wr_en      = 1'b1;
                    ram_wr_data    = init_addr_reg[31:PAGE_SHIFT];
                    count_next     = count_reg + CW'(1);
                    init_addr_next = init_end;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            region_start_reg <= REGION_START_RESET;
            region_limit_reg <= REGION_LIMIT_RESET;
            count_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            region_start_reg <= region_start_next;
            region_limit_reg <= region_limit_next;
            count_reg        <= count_next;
            m_valid_reg      <= m_valid_next;
        end
        init_addr_reg  <= init_addr_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
        free_count_reg <= free_count_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_address = granted_reg;
    assign m_status          = status_reg;
    assign m_free_count      = free_count_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("stack count above capacity");

    a_alloc_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ALLOC |-> !m_valid_reg)
        else $error("result register busy when allocate data returns");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg == STATUS_EMPTY |-> granted_reg == '0)
        else $error("nonzero address on empty allocate");

    a_alloc_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_command == CMD_ALLOC && count_reg != '0 |=> count_reg == $past(count_dec))
        else $error("allocate did not pop one page");
`endif

endmodule

[verif/free_page_stack_checker.sv]
// Checker for the free page stack allocator: mirrors the page stack and compares each result item.
module free_page_stack_checker
    import fpsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_page_address,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_granted_address,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_free_count,

    output int          fail_count
);

    localparam int unsigned PG_SHIFT    = PAGE_SHIFT_DEFAULT;
    localparam int unsigned DEPTH       = MAX_PAGES_DEFAULT;
    localparam logic [63:0] PG_BYTES    = 64'd1 << PG_SHIFT;
    localparam int          MAX_REPORTS = 60;

    typedef struct packed {
        logic [31:0] granted;
        logic [1:0]  status;
        logic [15:0] count;
    } page_result_t;

    logic [31-PG_SHIFT:0] page_stack_mirror [DEPTH];
    int unsigned          pages_held;
    logic [31:0]          start_reg;
    logic [31:0]          limit_reg;
    page_result_t         queued_results [$];
    int                   mismatches  = 0;
    int                   outstanding = 0;

    assign fail_count = mismatches + outstanding;

    function automatic page_result_t apply_command(input logic [1:0] cmd,
                                                   input logic [31:0] addr);
        page_result_t r;
        logic [63:0]  p;
        r = '0;
        r.status = STATUS_OK;
        case (cmd)
            CMD_FREE: begin
                if (addr[PG_SHIFT-1:0] != '0 || addr < start_reg || addr >= limit_reg) begin
                    r.status = STATUS_BAD_ADDR;
                end else if (pages_held >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    page_stack_mirror[pages_held] = addr[31:PG_SHIFT];
                    pages_held++;
                end
            end
            CMD_ALLOC: begin
                if (pages_held == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    pages_held--;
                    r.granted = {page_stack_mirror[pages_held], {PG_SHIFT{1'b0}}};
                end
            end
            CMD_INIT: begin
                p = ({32'd0, start_reg} + PG_BYTES - 64'd1) & ~(PG_BYTES - 64'd1);
                pages_held = 0;
                while (p + PG_BYTES <= {32'd0, limit_reg} && r.status == STATUS_OK) begin
                    if (pages_held >= DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        page_stack_mirror[pages_held] = p[31:PG_SHIFT];
                        pages_held++;
                        p += PG_BYTES;
                    end
                end
            end
            default: ;
        endcase
        r.count = pages_held[15:0];
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        page_result_t want;
        if (!aresetn) begin
            pages_held = 0;
            start_reg  = REGION_START_RESET;
            limit_reg  = REGION_LIMIT_RESET;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_REGION_START)
                    start_reg = cfg_wr_data;
                else
                    limit_reg = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (queued_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result item with nothing expected, granted %h status %h count %h",
                                 $time, m_granted_address, m_status, m_free_count);
                end else begin
                    want = queued_results.pop_front();
                    outstanding--;
                    check_field("granted_address", want.granted, m_granted_address);
                    check_field("status", 32'(want.status), 32'(m_status));
                    check_field("free_count", 32'(want.count), 32'(m_free_count));
                end
            end
            if (s_valid && s_ready) begin
                queued_results.push_back(apply_command(s_command, s_page_address));
                outstanding++;
            end
        end
    end

endmodule

[verif/tb_free_page_stack_allocator.sv]
// Testbench top for the free page stack allocator: clock, reset, command stimulus and verdict.
module tb_free_page_stack_allocator;
    import fpsa_pkg::*;

    localparam int unsigned PG_SHIFT      = PAGE_SHIFT_DEFAULT;
    localparam int unsigned PG_MASK       = (1 << PG_SHIFT) - 1;
    localparam logic [1:0]  CMD_RESERVED  = 2'd3;
    localparam int          IDLE_PCT      = 21;
    localparam int          RANDOM_ITEMS  = 1350;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          STALL_LIMIT   = 200000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [31:0] s_page_address;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_granted_address;
    logic [1:0]  m_status;
    logic [15:0] m_free_count;

    int          fail_count;
    int          items_sent    = 0;
    int          results_taken = 0;
    int          quiet_cycles  = 0;
    logic        steady;
    logic [31:0] region_lo;
    logic [31:0] region_hi;

    always #5 aclk = ~aclk;

    free_page_stack_allocator u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_page_address    (s_page_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status),
        .m_free_count      (m_free_count)
    );

    free_page_stack_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_page_address    (s_page_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_address (m_granted_address),
        .m_status          (m_status),
        .m_free_count      (m_free_count),
        .fail_count        (fail_count)
    );

    always @(negedge aclk)
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            items_sent <= items_sent + 1;
        if (aresetn && m_valid && m_ready)
            results_taken <= results_taken + 1;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [31:0] addr);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_page_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_taken != items_sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_region(input logic [31:0] start, input logic [31:0] limit);
        settle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_REGION_START;
        cfg_wr_data <= start;
        @(negedge aclk);
        cfg_index   <= REG_REGION_LIMIT;
        cfg_wr_data <= limit;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        region_lo = start;
        region_hi = limit;
    endtask

    // pick an aligned page inside the current region, or any address if it is empty
    function automatic logic [31:0] region_page();
        logic [63:0] lo;
        logic [63:0] span;
        lo = ({32'd0, region_lo} + 64'(PG_MASK)) & ~64'(PG_MASK);
        if (lo >= {32'd0, region_hi})
            return $urandom;
        span = ({32'd0, region_hi} - 64'd1 - lo) >> PG_SHIFT;
        return lo[31:0] + ($urandom_range(0, span[31:0]) << PG_SHIFT);
    endfunction

    initial begin
        int          random_items;
        int          phase;
        int          burst;
        int          pick;
        int          mode;
        logic [31:0] lo_addr;
        logic [31:0] hi_addr;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_REGION_START;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_command      = CMD_FREE;
        s_page_address = '0;
        steady         = 1'b0;
        region_lo      = REGION_START_RESET;
        region_hi      = REGION_LIMIT_RESET;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(CMD_ALLOC, 32'h0000_0000);
        send_item(CMD_FREE, 32'h8002_0000);
        send_item(CMD_FREE, 32'h8002_0001);
        send_item(CMD_FREE, 32'h8001_F000);
        send_item(CMD_FREE, 32'h8800_0000);
        send_item(CMD_FREE, 32'hFFFF_FFFF);
        send_item(CMD_FREE, 32'h0000_0000);
        send_item(CMD_RESERVED, 32'hFFFF_FFFF);
        send_item(CMD_FREE, 32'h87FF_F000);
        send_item(CMD_FREE, 32'h87FF_F000);
        send_item(CMD_ALLOC, 32'hFFFF_FFFF);
        send_item(CMD_ALLOC, 32'h0000_0000);
        send_item(CMD_ALLOC, 32'h0000_0000);
        send_item(CMD_ALLOC, 32'h0000_0000);

        set_region(32'h8000_0801, 32'h8000_5000);
        send_item(CMD_INIT, 32'h0000_0000);
        send_item(CMD_FREE, 32'h8000_0000);
        send_item(CMD_FREE, 32'h8000_5000);
        send_item(CMD_ALLOC, 32'h0000_0000);

        set_region(32'h0000_0000, 32'hFFFF_FFFF);
        send_item(CMD_INIT, 32'hFFFF_FFFF);
        send_item(CMD_FREE, 32'h0000_1000);
        send_item(CMD_ALLOC, 32'h0000_0000);

        set_region(32'hFFFF_C000, 32'hFFFF_FFFF);
        send_item(CMD_INIT, 32'h0000_0000);
        send_item(CMD_FREE, 32'hFFFF_F000);

        set_region(32'hFFFF_F001, 32'hFFFF_FFFF);
        send_item(CMD_INIT, 32'h0000_0000);
        set_region(32'h5000_0000, 32'h0000_0000);
        send_item(CMD_INIT, 32'h0000_0000);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 11);
            lo_addr = $urandom;
            if (mode == 0)
                lo_addr = $urandom_range(0, PG_MASK);
            else if (mode == 3)
                lo_addr[PG_SHIFT-1:0] = '0;
            hi_addr = lo_addr + ($urandom_range(0, 48) << PG_SHIFT) + $urandom_range(0, PG_MASK);
            if (mode == 1) begin
                hi_addr = 32'hFFFF_FFFF;
                lo_addr = hi_addr - ($urandom_range(0, 40) << PG_SHIFT)
                          - $urandom_range(0, PG_MASK);
            end else if (mode == 2) begin
                hi_addr = $urandom;
            end
            steady = (phase == 2);
            set_region(lo_addr, hi_addr);
            send_item(CMD_INIT, $urandom);
            burst = $urandom_range(60, 140);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 38)
                    send_item(CMD_ALLOC, $urandom);
                else if (pick < 76)
                    send_item(CMD_FREE, region_page());
                else if (pick < 80)
                    send_item(CMD_FREE, region_page() | $urandom_range(1, PG_MASK));
                else if (pick < 84)
                    send_item(CMD_FREE, region_lo - ($urandom_range(1, 8) << PG_SHIFT));
                else if (pick < 88)
                    send_item(CMD_FREE, region_hi + ($urandom_range(0, 8) << PG_SHIFT));
                else if (pick < 93)
                    send_item(CMD_FREE, $urandom);
                else if (pick < 98)
                    send_item(CMD_RESERVED, $urandom);
                else
                    send_item(CMD_INIT, $urandom);
            end
            random_items += burst + 1;
            phase++;
        end

        steady = 1'b0;
        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[free_page_stack_allocator.f]
hdl/fpsa_pkg.sv
hdl/fpsa_ram.sv
hdl/free_page_stack_allocator.sv
verif/free_page_stack_checker.sv
verif/tb_free_page_stack_allocator.sv
